// ----- rtl/core/neighbour_table_insert_lookup_defines.svh -----
// ----------------------------------------------------------------------------
// neighbour table assertion macros
// shared assertion wrappers for the neighbour table checker
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_TABLE_INSERT_LOOKUP_DEFINES_SVH
`define NEIGHBOUR_TABLE_INSERT_LOOKUP_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define NTIL_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("neighbour table assertion failed");

// assertion on the block clock and reset
`define NTIL_ASSERT(label, prop) \
    `NTIL_ASSERT_CLK(label, i_clk, i_rst_n, prop)

`endif

// ----- rtl/core/ntil_pkg.sv -----
// ----------------------------------------------------------------------------
// neighbour table package
// shared widths, codes and the search token passed along the cell row
// ----------------------------------------------------------------------------
package ntil_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int ADDR_W          = 16;
    localparam int RSSI_W          = 8;
    localparam int IDX_W           = 6;
    localparam int CNT_W           = 7;
    localparam int MODE_W          = 2;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic signed [RSSI_W-1:0] RSSI_FLOOR_RST = -8'sd80;
    localparam logic [ADDR_W-1:0]        MY_ID_RST      = '0;

    typedef enum logic [MODE_W-1:0] {
        MODE_BEACON = 2'd0,
        MODE_LIST   = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic {
        REG_RSSI_FLOOR = 1'b0,
        REG_MY_ID      = 1'b1
    } t_reg;

    typedef struct packed {
        logic              active;
        logic              key_ok;
        logic              insert;
        logic [ADDR_W-1:0] key;
        logic              hit;
        logic              added;
        logic [IDX_W-1:0]  idx;
    } t_token;

endpackage

// ----- rtl/core/ntil_cell.sv -----
// ----------------------------------------------------------------------------
// neighbour table cell
// holds one table slot, compares or captures the passing token, forwards it
// ----------------------------------------------------------------------------
module ntil_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_clear,
    input  ntil_pkg::t_token i_tok,
    output ntil_pkg::t_token o_tok
);

    logic [ntil_pkg::ADDR_W-1:0] r_entry;
    logic                        r_valid;
    ntil_pkg::t_token            r_tok;
    ntil_pkg::t_token            n_tok;
    logic                        w_match;
    logic                        w_take;

    always_comb begin
        w_match = i_tok.active && i_tok.key_ok && r_valid && (r_entry == i_tok.key);
        w_take  = i_tok.active && i_tok.insert && !r_valid && !i_tok.hit;
        n_tok   = i_tok;
        if (w_match || w_take) begin
            n_tok.hit = 1'b1;
            n_tok.idx = ntil_pkg::IDX_W'(CELL_IDX);
        end
        if (w_take) begin
            n_tok.added = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            if (i_clear) begin
                r_valid <= 1'b0;
            end else if (i_adv && w_take) begin
                r_valid <= 1'b1;
            end
            if (i_adv) begin
                r_tok <= n_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_take) begin
            r_entry <= i_tok.key;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- rtl/core/neighbour_table_insert_lookup.sv -----
// ----------------------------------------------------------------------------
// neighbour table insert and lookup
// table of neighbour addresses kept in a row of cells, searched by a token
// ----------------------------------------------------------------------------
// Each item launches a search token into a row of TABLE_DEPTH cells, one cell
// per slot; the token moves one cell per cycle while the output is not
// stalled, and the result of an item is registered when the token leaves
// the last cell. The next item is taken only after that exit, so the row holds
// one item at a time. A clear empties every slot at the input transfer
// itself. The result register holds a finished result until its output
// transfer; while it is stalled the token waits in the last cell.
module neighbour_table_insert_lookup #(
    parameter int TABLE_DEPTH = ntil_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ntil_pkg::MODE_W-1:0]         i_mode,
    input  logic [ntil_pkg::ADDR_W-1:0]         i_src_addr,
    input  logic signed [ntil_pkg::RSSI_W-1:0]  i_rssi,
    input  logic [ntil_pkg::ADDR_W-1:0]         i_list_word,
    input  logic                                i_list_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ntil_pkg::IDX_W-1:0]          o_entry_index,
    output logic                                o_found,
    output logic                                o_added,
    output logic                                o_rejected_weak,
    output logic                                o_own_id_seen,
    output logic [ntil_pkg::CNT_W-1:0]          o_neighbour_count,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ntil_pkg::PADDR_W-1:0]        paddr,
    input  logic [ntil_pkg::PDATA_W-1:0]        pwdata,
    output logic [ntil_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    ntil_pkg::t_token                    w_tok [TABLE_DEPTH+1];
    ntil_pkg::t_token                    w_launch;
    ntil_pkg::t_mode                     w_mode;
    logic                                w_in_acc;
    logic                                w_exit;
    logic                                w_adv;
    logic                                w_clear;
    logic                                w_cfg_wr;
    logic                                w_weak;
    logic                                w_own;
    logic                                w_ins;

    logic                                r_busy;
    logic                                r_out_valid;
    logic [ntil_pkg::IDX_W-1:0]          r_entry_index;
    logic                                r_found;
    logic                                r_added;
    logic                                r_rejected_weak;
    logic                                r_own_id_seen;
    logic [ntil_pkg::CNT_W-1:0]          r_neighbour_count;
    logic [ntil_pkg::CNT_W-1:0]          r_count;
    logic                                r_list_ended;
    logic                                n_list_ended;
    logic                                r_weak;
    logic                                r_own;
    logic signed [ntil_pkg::RSSI_W-1:0]  r_rssi_floor;
    logic [ntil_pkg::ADDR_W-1:0]         r_my_id;

    assign w_mode   = ntil_pkg::t_mode'(i_mode);
    assign w_in_acc = i_in_valid && !r_busy;
    assign w_exit   = w_tok[TABLE_DEPTH].active && (!r_out_valid || !i_out_stall);
    assign w_adv    = !(w_tok[TABLE_DEPTH].active && r_out_valid && i_out_stall);
    assign w_clear  = w_in_acc && (w_mode == ntil_pkg::MODE_CLEAR);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // item decode
    always_comb begin
        w_weak       = 1'b0;
        w_own        = 1'b0;
        w_ins        = 1'b0;
        n_list_ended = r_list_ended;
        case (w_mode)
            ntil_pkg::MODE_BEACON: begin
                w_weak = (i_rssi < r_rssi_floor);
                w_ins  = !w_weak;
            end
            ntil_pkg::MODE_LIST: begin
                if (!r_list_ended) begin
                    w_own = (i_list_word == r_my_id);
                    w_ins = w_own;
                    if (i_list_word == '0) begin
                        n_list_ended = 1'b1;
                    end
                end
                if (i_list_last) begin
                    n_list_ended = 1'b0;
                end
            end
            ntil_pkg::MODE_LOOKUP: begin
                w_ins = 1'b0;
            end
            ntil_pkg::MODE_CLEAR: begin
                n_list_ended = 1'b0;
            end
            default: begin
                w_ins = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_launch        = '0;
        w_launch.active = w_in_acc;
        w_launch.key_ok = (w_mode != ntil_pkg::MODE_CLEAR) && (i_src_addr != '0);
        w_launch.insert = w_ins && w_launch.key_ok;
        w_launch.key    = i_src_addr;
    end

    assign w_tok[0] = w_launch;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ntil_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_clear (w_clear),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_count      <= '0;
            r_list_ended <= 1'b0;
            r_rssi_floor <= ntil_pkg::RSSI_FLOOR_RST;
            r_my_id      <= ntil_pkg::MY_ID_RST;
        end else begin
            if (w_in_acc) begin
                r_busy       <= 1'b1;
                r_list_ended <= n_list_ended;
            end else if (w_exit) begin
                r_busy <= 1'b0;
            end
            if (w_clear) begin
                r_count <= '0;
            end else if (w_exit) begin
                r_count <= r_count + ntil_pkg::CNT_W'(w_tok[TABLE_DEPTH].added);
            end
            if (w_exit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                case (ntil_pkg::t_reg'(paddr[2]))
                    ntil_pkg::REG_RSSI_FLOOR: r_rssi_floor <= pwdata[ntil_pkg::RSSI_W-1:0];
                    ntil_pkg::REG_MY_ID:      r_my_id      <= pwdata[ntil_pkg::ADDR_W-1:0];
                    default:                  r_my_id      <= r_my_id;
                endcase
            end
        end
    end

    // item flags and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_weak <= w_weak;
            r_own  <= w_own;
        end
        if (w_exit) begin
            r_entry_index     <= w_tok[TABLE_DEPTH].idx;
            r_found           <= w_tok[TABLE_DEPTH].hit;
            r_added           <= w_tok[TABLE_DEPTH].added;
            r_rejected_weak   <= r_weak;
            r_own_id_seen     <= r_own;
            r_neighbour_count <= r_count + ntil_pkg::CNT_W'(w_tok[TABLE_DEPTH].added);
        end
    end

    always_comb begin
        case (ntil_pkg::t_reg'(paddr[2]))
            ntil_pkg::REG_RSSI_FLOOR: prdata = {{(ntil_pkg::PDATA_W-ntil_pkg::RSSI_W){1'b0}},
                                                r_rssi_floor};
            ntil_pkg::REG_MY_ID:      prdata = {{(ntil_pkg::PDATA_W-ntil_pkg::ADDR_W){1'b0}},
                                                r_my_id};
            default:                  prdata = '0;
        endcase
    end

    assign pready            = 1'b1;
    assign o_in_stall        = r_busy;
    assign o_out_valid       = r_out_valid;
    assign o_entry_index     = r_entry_index;
    assign o_found           = r_found;
    assign o_added           = r_added;
    assign o_rejected_weak   = r_rejected_weak;
    assign o_own_id_seen     = r_own_id_seen;
    assign o_neighbour_count = r_neighbour_count;

endmodule

// ----- rtl/core/ntil_checker.sv -----
// ----------------------------------------------------------------------------
// neighbour table checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "neighbour_table_insert_lookup_defines.svh"

module ntil_checker #(
    parameter int TABLE_DEPTH = ntil_pkg::DEF_TABLE_DEPTH
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [ntil_pkg::IDX_W-1:0]  o_entry_index,
    input logic                        o_found,
    input logic                        o_added,
    input logic                        o_rejected_weak,
    input logic [ntil_pkg::CNT_W-1:0]  o_neighbour_count
);

    `NTIL_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid)
    `NTIL_ASSERT(a_added_found, o_out_valid && o_added |-> o_found && !o_rejected_weak)
    `NTIL_ASSERT(a_miss_index_zero, o_out_valid && !o_found |-> o_entry_index == '0)
    `NTIL_ASSERT(a_hit_in_range, o_out_valid && o_found |->
        (ntil_pkg::CNT_W'(o_entry_index) < o_neighbour_count) &&
        (o_neighbour_count <= ntil_pkg::CNT_W'(TABLE_DEPTH)))

endmodule

bind neighbour_table_insert_lookup ntil_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_ntil_checker (.*);

// ----- bench/neighbour_table_insert_lookup_tb.sv -----
// ----------------------------------------------------------------------------
// neighbour table insert and lookup testbench
// drives beacons, neighbour list words, lookups and clears through the
// valid/stall input channel and checks every result transfer against a
// predictor of the address table kept in the bench; the rssi floor and my_id
// are set over the apb port between phases and read back
// ----------------------------------------------------------------------------
module neighbour_table_insert_lookup_tb;
    import ntil_pkg::*;

    localparam int DEPTH        = DEF_TABLE_DEPTH;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 150;
    localparam int POOL_SIZE    = 24;

    typedef struct {
        t_mode                    mode;
        logic [ADDR_W-1:0]        src;
        logic signed [RSSI_W-1:0] rssi;
        logic [ADDR_W-1:0]        word;
        logic                     last;
    } t_frame;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             found;
        logic             added;
        logic             low_sig;
        logic             own;
        logic [CNT_W-1:0] count;
    } t_report;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     o_in_stall;
    logic [MODE_W-1:0]        in_mode = '0;
    logic [ADDR_W-1:0]        in_src = '0;
    logic signed [RSSI_W-1:0] in_rssi = '0;
    logic [ADDR_W-1:0]        in_word = '0;
    logic                     in_last = 1'b0;
    logic                     o_out_valid;
    logic                     out_stall = 1'b0;
    logic [IDX_W-1:0]         o_entry_index;
    logic                     o_found;
    logic                     o_added;
    logic                     o_rejected_weak;
    logic                     o_own_id_seen;
    logic [CNT_W-1:0]         o_neighbour_count;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    // predictor state
    logic [ADDR_W-1:0]        nbr_slots [DEPTH];
    int                       nbr_count = 0;
    bit                       list_closed = 1'b0;
    logic signed [RSSI_W-1:0] cfg_rssi_floor = RSSI_FLOOR_RST;
    logic [ADDR_W-1:0]        cfg_my_id = MY_ID_RST;
    t_report                  pending_results [$];

    logic [ADDR_W-1:0]        addr_pool [POOL_SIZE];
    bit                       quiet = 1'b0;
    int                       hold_left = 0;
    int                       stall_left = 0;
    int                       cycle_count = 0;
    int                       mismatches = 0;
    int                       items_sent = 0;
    int                       results_checked = 0;
    int                       n_added = 0;
    int                       n_weak = 0;
    int                       n_own = 0;
    int                       n_full = 0;
    int                       n_hold_stalls = 0;

    neighbour_table_insert_lookup #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (in_mode),
        .i_src_addr        (in_src),
        .i_rssi            (in_rssi),
        .i_list_word       (in_word),
        .i_list_last       (in_last),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_entry_index     (o_entry_index),
        .o_found           (o_found),
        .o_added           (o_added),
        .o_rejected_weak   (o_rejected_weak),
        .o_own_id_seen     (o_own_id_seen),
        .o_neighbour_count (o_neighbour_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL neighbour_table_insert_lookup");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int slot_of(logic [ADDR_W-1:0] addr);
        int s;
        s = -1;
        if (addr != '0) begin
            for (int i = 0; i < nbr_count && i < DEPTH; i++) begin
                if (nbr_slots[i] == addr && s < 0) s = i;
            end
        end
        return s;
    endfunction

    function automatic logic try_insert(logic [ADDR_W-1:0] addr);
        if (addr == '0 || slot_of(addr) >= 0) return 1'b0;
        if (nbr_count >= DEPTH) begin
            n_full++;
            return 1'b0;
        end
        nbr_slots[nbr_count] = addr;
        nbr_count++;
        n_added++;
        return 1'b1;
    endfunction

    function automatic t_report apply_frame(t_frame f);
        t_report r;
        int      slot;
        r = '0;
        case (f.mode)
            MODE_BEACON: begin
                if (f.rssi < cfg_rssi_floor) begin
                    r.low_sig = 1'b1;
                    n_weak++;
                end else begin
                    r.added = try_insert(f.src);
                end
            end
            MODE_LIST: begin
                if (!list_closed) begin
                    if (f.word == cfg_my_id) begin
                        r.own = 1'b1;
                        n_own++;
                        r.added = try_insert(f.src);
                    end
                    if (f.word == '0) list_closed = 1'b1;
                end
                if (f.last) list_closed = 1'b0;
            end
            MODE_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) nbr_slots[i] = '0;
                nbr_count = 0;
                list_closed = 1'b0;
            end
            default: ;
        endcase
        if (f.mode != MODE_CLEAR) begin
            slot = slot_of(f.src);
            if (slot >= 0) begin
                r.found = 1'b1;
                r.idx = IDX_W'(slot);
            end
        end
        r.count = CNT_W'(nbr_count);
        return r;
    endfunction

    function automatic string fmt_report(t_report r);
        return $sformatf("idx %0d found %0b added %0b weak %0b own %0b count %0d",
                         r.idx, r.found, r.added, r.low_sig, r.own, r.count);
    endfunction

    function automatic void report_mismatch(string what, string want_s, string got_s);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s) at cycle %0d: expected %s, got %s",
                     what, cycle_count, want_s, got_s);
        end
    endfunction

    function automatic int rand_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // result checking and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            got = {o_entry_index, o_found, o_added, o_rejected_weak, o_own_id_seen,
                   o_neighbour_count};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", "none", fmt_report(got));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.idx !== want.idx || got.found !== want.found ||
                    got.added !== want.added || got.low_sig !== want.low_sig ||
                    got.own !== want.own || got.count !== want.count) begin
                    report_mismatch("result", fmt_report(want), fmt_report(got));
                end
            end
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
                n_hold_stalls++;
            end else if (quiet) begin
                out_stall = 1'b0;
            end else if (stall_left > 0) begin
                out_stall = 1'b1;
                stall_left--;
            end else if ($urandom_range(0, 99) < 80) begin
                out_stall = 1'b0;
            end else begin
                out_stall = 1'b1;
                stall_left = rand_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send(t_mode m, logic [ADDR_W-1:0] src, logic signed [RSSI_W-1:0] rssi,
                        logic [ADDR_W-1:0] word, logic last);
        t_frame f;
        int     gap;
        f.mode = m;
        f.src  = src;
        f.rssi = rssi;
        f.word = word;
        f.last = last;
        gap = rand_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_mode  = f.mode;
        in_src   = f.src;
        in_rssi  = f.rssi;
        in_word  = f.word;
        in_last  = f.last;
        in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(apply_frame(f));
        items_sent++;
        @(negedge i_clk);
    endtask

    // sender pauses until every outstanding result has come back
    task automatic drain();
        in_valid = 1'b0;
        wait (pending_results.size() == 0);
        @(negedge i_clk);
    endtask

    task automatic set_register(t_reg r, logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] mask;
        mask = (r == REG_RSSI_FLOOR) ? PDATA_W'(8'hFF) : PDATA_W'(16'hFFFF);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(4 * int'(r));
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (r == REG_RSSI_FLOOR) cfg_rssi_floor = data[RSSI_W-1:0];
        else cfg_my_id = data[ADDR_W-1:0];
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== (data & mask)) begin
            report_mismatch("register readback", $sformatf("%0h", data & mask),
                            $sformatf("%0h", prdata & mask));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] pick_src();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return addr_pool[$urandom_range(0, POOL_SIZE-1)];
        if (r < 92) return '0;
        return ADDR_W'($urandom);
    endfunction

    task automatic random_traffic(int n);
        int                       sent;
        int                       r;
        int                       len;
        int                       q;
        logic [ADDR_W-1:0]        src;
        logic [ADDR_W-1:0]        w;
        logic signed [RSSI_W-1:0] rs;
        sent = 0;
        for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = ADDR_W'($urandom_range(1, 65535));
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                rs = ($urandom_range(0, 3) == 0) ? cfg_rssi_floor : RSSI_W'($urandom);
                send(MODE_BEACON, pick_src(), rs, ADDR_W'($urandom), 1'($urandom));
                sent++;
            end else if (r < 70) begin
                // one neighbour list packet from one sender
                len = $urandom_range(1, 8);
                src = pick_src();
                for (int k = 0; k < len; k++) begin
                    q = $urandom_range(0, 99);
                    if (q < 35) w = cfg_my_id;
                    else if (q < 50) w = '0;
                    else if (q < 75) w = addr_pool[$urandom_range(0, POOL_SIZE-1)];
                    else w = ADDR_W'($urandom);
                    send(MODE_LIST, src, RSSI_W'($urandom), w, k == len - 1);
                    sent++;
                end
            end else if (r < 90) begin
                send(MODE_LOOKUP, pick_src(), RSSI_W'($urandom), ADDR_W'($urandom),
                     1'($urandom));
                sent++;
            end else if (r < 92) begin
                send(MODE_CLEAR, ADDR_W'($urandom), RSSI_W'($urandom), ADDR_W'($urandom),
                     1'($urandom));
                sent++;
            end else begin
                // noise, including list words with a broken last marker
                send(t_mode'($urandom_range(0, 3)), ADDR_W'($urandom), RSSI_W'($urandom),
                     ADDR_W'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_beacons();
        send(MODE_BEACON, 16'h0000, 8'sd127, 16'h0000, 1'b0);
        send(MODE_BEACON, 16'h0001, -8'sd81, 16'hFFFF, 1'b1);
        send(MODE_BEACON, 16'h0001, -8'sd80, 16'h0000, 1'b0);
        send(MODE_BEACON, 16'h0001, 8'sd127, 16'h0000, 1'b0);
        send(MODE_BEACON, 16'hFFFF, -8'sd128, 16'h0000, 1'b0);
        send(MODE_BEACON, 16'hFFFF, 8'sd127, 16'h0000, 1'b0);
        send(MODE_LOOKUP, 16'hFFFF, 8'sd0, 16'h0000, 1'b0);
        send(MODE_LOOKUP, 16'h8000, 8'sd0, 16'h0000, 1'b0);
        send(MODE_LOOKUP, 16'h0000, 8'sd0, 16'h0000, 1'b0);
    endtask

    // my_id is still zero here, so the zero word that ends a list matches
    task automatic test_lists();
        send(MODE_LIST, 16'h0100, 8'sd0, 16'h0005, 1'b0);
        send(MODE_LIST, 16'h0200, 8'sd0, 16'h0000, 1'b0);
        send(MODE_LIST, 16'h0300, 8'sd0, 16'h0000, 1'b0);
        send(MODE_LIST, 16'h0300, 8'sd0, 16'h0000, 1'b1);
        send(MODE_LIST, 16'h0000, 8'sd0, 16'h0000, 1'b1);
        send(MODE_CLEAR, 16'hABCD, -8'sd1, 16'hFFFF, 1'b1);
        send(MODE_LOOKUP, 16'h0200, 8'sd0, 16'h0000, 1'b0);
    endtask

    task automatic test_full_table();
        for (int i = 1; i <= DEPTH + 1; i++) begin
            send(MODE_BEACON, ADDR_W'(16'h1000 + i), 8'sd127, 16'h0000, 1'b0);
        end
        send(MODE_LOOKUP, ADDR_W'(16'h1000 + DEPTH), 8'sd0, 16'h0000, 1'b0);
    endtask

    task automatic test_registers();
        drain();
        set_register(REG_RSSI_FLOOR, 32'h0000_0080);
        set_register(REG_MY_ID, 32'h0000_FFFF);
        send(MODE_CLEAR, 16'h0000, 8'sd0, 16'h0000, 1'b0);
        send(MODE_BEACON, 16'h2222, -8'sd128, 16'h0000, 1'b0);
        send(MODE_LIST, 16'h3333, 8'sd0, 16'hFFFF, 1'b1);
        drain();
        set_register(REG_RSSI_FLOOR, 32'h0000_007F);
        send(MODE_BEACON, 16'h4444, 8'sd126, 16'h0000, 1'b0);
        send(MODE_BEACON, 16'h4444, 8'sd127, 16'h0000, 1'b0);
    endtask

    task automatic test_random_phases();
        logic [PDATA_W-1:0] rssi_set [6];
        logic [PDATA_W-1:0] id_set [6];
        rssi_set = '{32'h80, 32'h7F, 32'hB0, 32'h00, 32'($urandom_range(0, 255)),
                     32'($urandom_range(0, 255))};
        id_set   = '{32'hFFFF, 32'($urandom_range(1, 65535)), 32'h0000,
                     32'($urandom_range(1, 65535)), 32'($urandom_range(0, 65535)), 32'h0001};
        for (int p = 0; p < 6; p++) begin
            drain();
            set_register(REG_RSSI_FLOOR, rssi_set[p]);
            set_register(REG_MY_ID, id_set[p]);
            quiet = (p == 2);
            random_traffic(PHASE_ITEMS);
            quiet = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        drain();
        set_register(REG_RSSI_FLOOR, 32'h0000_00C0);
        hold_left = 400;
        random_traffic(30);
        drain();
        random_traffic(40);
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) nbr_slots[i] = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_beacons();
        test_lists();
        test_full_table();
        test_registers();
        test_random_phases();
        test_backpressure();

        drain();
        repeat (2 * (DEPTH + 2)) @(posedge i_clk);
        $display("covered %0d transfers, %0d results checked, %0d inserts, %0d weak beacons",
                 items_sent, results_checked, n_added, n_weak);
        $display("own id matches %0d, full table refusals %0d, long hold %0d cycles",
                 n_own, n_full, n_hold_stalls);
        if (mismatches == 0) begin
            $display("PASS neighbour_table_insert_lookup");
        end else begin
            $display("FAIL neighbour_table_insert_lookup");
        end
        $finish;
    end

endmodule
